// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL file of the constant table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define CFTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CFTU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CFTU_ASSERT(lbl, prop, msg)
`define CFTU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/crcft_pkg.sv =====
// Constants, codes and the shift-xor step of the CRC fold constant table unit.
package crcft_pkg;

  // Table geometry
  localparam int INNER_UNROLL     = 2048;
  localparam int OUTER_UNROLL     = 8;
  localparam int BYTE_TABLE_WORDS = 256;

  // Field widths
  localparam int IDX_W     = 11;
  localparam int IN_DATA_W = ((IDX_W + 7) / 8) * 8;
  localparam int WORD_W    = 32;
  localparam int LOG_W     = $clog2(WORD_W);

  // Section boundaries of the table
  localparam int FOLDS_Q     = INNER_UNROLL / OUTER_UNROLL;
  localparam int OUTER_WORDS = 4 * (OUTER_UNROLL - 1);
  localparam int INNER_WORDS = 4 * FOLDS_Q;
  localparam int OUTER_END   = BYTE_TABLE_WORDS + OUTER_WORDS;
  localparam int INNER_END   = OUTER_END + INNER_WORDS;
  localparam int TABLE_END   = INNER_END + 4;
  localparam int CMP_W       = ($clog2(TABLE_END + 1) > IDX_W + 1) ?
                               $clog2(TABLE_END + 1) : IDX_W + 1;

  // Largest fold count and the widths that follow from it
  localparam int FOLD_STRIDE   = 4 * OUTER_UNROLL;
  localparam int INNER_FOLDMAX = (FOLDS_Q > 0) ? FOLD_STRIDE * (FOLDS_Q - 1) + 4 : 0;
  localparam int FOLD_MAX      = (INNER_FOLDMAX > OUTER_WORDS) ? INNER_FOLDMAX : OUTER_WORDS;
  localparam int N_W           = $clog2(FOLD_MAX + 1);
  localparam int K_W           = (FOLDS_Q > 1) ? $clog2(FOLDS_Q) : 1;
  localparam int EXP_W         = N_W + LOG_W;
  localparam int EBIT_W        = $clog2(EXP_W);
  localparam int NORM_W        = $clog2(WORD_W + 1);
  localparam int CNT_W         = $clog2(2 * WORD_W + 1);
  localparam int BYTE_STEPS    = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_POLY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENDIAN = 1'd1;

  localparam logic [WORD_W-1:0] POLY_RESET = 32'hEDB8_8320;

  // Request kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FOLD = 2'd1;
  localparam logic [1:0] KIND_POLY = 2'd2;
  localparam logic [1:0] KIND_OOR  = 2'd3;

  // The value 1 in the reflected domain (top-degree coefficient in bit 0 order)
  localparam logic [WORD_W-1:0] FOLD_ONE = {1'b1, {(WORD_W-1){1'b0}}};

  // One reflected shift-xor step: multiply by x modulo the polynomial
  function automatic logic [WORD_W-1:0] mulx(input logic [WORD_W-1:0] v,
                                             input logic [WORD_W-1:0] poly);
    return (v >> 1) ^ (v[0] ? poly : '0);
  endfunction

endpackage

// ===== src/crc_fold_constant_table_unit.sv =====
// CRC fold constant table unit: returns one word of the fold/Barrett table per request.
// Byte words come from shift-xor steps; fold words from bit-serial squaring over the exponent
// bits; polynomial words from a normalising shift, then long division.
// Throughput: one request at a time, set by the single bit-serial GF(2) multiply/divide unit;
// a finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous): polynomial 0xEDB88320, little-endian, no result pending.
`include "assert_macros.svh"

module crc_fold_constant_table_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [crcft_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [10:0] entry_index
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [crcft_pkg::WORD_W-1:0]         m_axis_tdata,  // [31:0] table_word
  output logic                                 m_axis_tuser,  // [0] out_of_range
  input  logic                                 cfg_we_i,
  input  logic [crcft_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [crcft_pkg::WORD_W-1:0]         cfg_data_i
);
  import crcft_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BYTE = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_NORM = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [LOG_W-1:0] EXP_LOW = '1;

  // Configuration
  logic [WORD_W-1:0] poly_q;
  logic              le_q;

  // Control
  logic [2:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;

  // Datapath
  logic [1:0]        kind_q, kind_d;
  logic [1:0]        pick_q, pick_d;
  logic [WORD_W-1:0] res_q, res_d;
  logic [WORD_W-1:0] base_q, base_d;
  logic [WORD_W-1:0] sh_q, sh_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  logic [EBIT_W-1:0] ebit_q, ebit_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [NORM_W-1:0] norm_q, norm_d;
  logic [WORD_W:0]   div_q, div_d;
  logic [WORD_W:0]   rem_q, rem_d;
  logic [2*WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              flag_q, flag_d;

  // Request decode
  logic              in_accept;
  logic [CMP_W-1:0]  idx_ext, j_out, j_in, j_poly;
  logic [N_W-1:0]    jq_n, n3, n_outer, base_n, n_inner, in_fold;
  logic [K_W-1:0]    k_blk;
  logic [1:0]        in_kind, in_pick;

  // Step logic
  logic [WORD_W-1:0] sq_step, sq_last;
  logic              qbit;
  logic [WORD_W:0]   rem_x;
  logic [WORD_W-1:0] poly_word;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = word_q;
  assign m_axis_tuser  = flag_q;

  // Hold the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RESET;
      le_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLY:   poly_q <= cfg_data_i;
        REG_ENDIAN: le_q   <= cfg_data_i[0];
      endcase
    end
  end

  // Decode the index into a section, a fold count and a word pick
  always_comb begin
    idx_ext = CMP_W'(s_axis_tdata[IDX_W-1:0]);
    j_out   = idx_ext - CMP_W'(BYTE_TABLE_WORDS);
    j_in    = idx_ext - CMP_W'(OUTER_END);
    j_poly  = idx_ext - CMP_W'(INNER_END);

    jq_n    = N_W'(j_out >> 2);
    n3      = (jq_n + N_W'(1)) << 2;
    n_outer = ((j_out[0] == 1'b0) == le_q) ? n3 : n3 - N_W'(1);

    k_blk   = K_W'(FOLDS_Q - 1) - K_W'(j_in >> 2);
    base_n  = N_W'(FOLD_STRIDE) * N_W'(k_blk);
    n_inner = le_q ? base_n + N_W'(4) - N_W'(j_in[1:0])
                   : base_n + N_W'(1) + N_W'(j_in[1:0]);

    in_fold = n_outer;
    in_pick = j_poly[1:0];
    priority if (idx_ext < CMP_W'(BYTE_TABLE_WORDS)) begin
      in_kind = KIND_BYTE;
    end else if (idx_ext < CMP_W'(OUTER_END)) begin
      in_kind = KIND_FOLD;
    end else if (idx_ext < CMP_W'(INNER_END)) begin
      in_kind = KIND_FOLD;
      in_fold = n_inner;
    end else if (idx_ext < CMP_W'(TABLE_END)) begin
      in_kind = KIND_POLY;
    end else begin
      in_kind = KIND_OOR;
    end
  end

  // One Horner step of the square, and the closing multiply by x for a set exponent bit
  assign sq_step = mulx(res_q, poly_q) ^ (sh_q[0] ? base_q : '0);
  assign sq_last = exp_q[EXP_W-1] ? mulx(sq_step, poly_q) : sq_step;

  // One long-division step against the normalised divisor
  assign qbit  = rem_q[WORD_W];
  assign rem_x = qbit ? (rem_q ^ div_q) : rem_q;

  // Select a polynomial or quotient word by endianness and position
  always_comb begin
    if (le_q) begin
      unique case (pick_q)
        2'd0: poly_word = quo_q[WORD_W-1:0];
        2'd1: poly_word = quo_q[2*WORD_W-1:WORD_W];
        2'd2: poly_word = {poly_q[WORD_W-2:0], 1'b1};
        2'd3: poly_word = {{(WORD_W-1){1'b0}}, poly_q[WORD_W-1]};
      endcase
    end else begin
      unique case (pick_q)
        2'd0: poly_word = {{(WORD_W-1){1'b0}}, poly_q[WORD_W-1]};
        2'd1: poly_word = {poly_q[WORD_W-2:0], 1'b1};
        2'd2: poly_word = quo_q[2*WORD_W-1:WORD_W];
        2'd3: poly_word = quo_q[WORD_W-1:0];
      endcase
    end
  end

  // Sequence the request through the shared bit-serial unit
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    pick_d      = pick_q;
    res_d       = res_q;
    base_d      = base_q;
    sh_d        = sh_q;
    exp_d       = exp_q;
    ebit_d      = ebit_q;
    cnt_d       = cnt_q;
    norm_d      = norm_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    word_d      = word_q;
    flag_d      = flag_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          kind_d = in_kind;
          pick_d = in_pick;
          cnt_d  = '0;
          unique case (in_kind)
            KIND_BYTE: begin
              res_d   = WORD_W'(s_axis_tdata[IDX_W-1:0]);
              state_d = ST_BYTE;
            end
            KIND_FOLD: begin
              base_d  = FOLD_ONE;
              sh_d    = FOLD_ONE;
              res_d   = '0;
              exp_d   = {in_fold, EXP_LOW};
              ebit_d  = EBIT_W'(EXP_W - 1);
              state_d = ST_SQR;
            end
            KIND_POLY: begin
              div_d   = {poly_q, 1'b1};
              norm_d  = '0;
              quo_d   = '0;
              state_d = ST_NORM;
            end
            KIND_OOR: begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_BYTE: begin
        res_d = mulx(res_q, poly_q);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(BYTE_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_SQR: begin
        sh_d  = sh_q >> 1;
        cnt_d = cnt_q + CNT_W'(1);
        res_d = sq_step;
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          exp_d = exp_q << 1;
          cnt_d = '0;
          if (ebit_q == '0) begin
            res_d   = sq_last;
            state_d = ST_DONE;
          end else begin
            base_d = sq_last;
            sh_d   = sq_last;
            res_d  = '0;
            ebit_d = ebit_q - EBIT_W'(1);
          end
        end
      end
      ST_NORM: begin
        if (div_q[WORD_W]) begin
          if (norm_q == NORM_W'(WORD_W)) begin
            // divisor is 1: quotient overflows and reads as zero
            state_d = ST_DONE;
          end else begin
            rem_d   = {1'b1, {WORD_W{1'b0}}};
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        end else begin
          div_d  = div_q << 1;
          norm_d = norm_q + NORM_W'(1);
        end
      end
      ST_DIV: begin
        rem_d = {rem_x[WORD_W-1:0], 1'b0};
        quo_d = {quo_q[2*WORD_W-2:0], qbit};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_W) + CNT_W'(norm_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          word_d      = (kind_q == KIND_POLY) ? poly_word : res_q;
          flag_d      = (kind_q == KIND_OOR);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the datapath registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    pick_q <= pick_d;
    res_q  <= res_d;
    base_q <= base_d;
    sh_q   <= sh_d;
    exp_q  <= exp_d;
    ebit_q <= ebit_d;
    cnt_q  <= cnt_d;
    norm_q <= norm_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    word_q <= word_d;
    flag_q <= flag_d;
  end

  `CFTU_ASSERT(oor_word_zero_a, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "out-of-range result carries a nonzero word")
  `CFTU_ASSERT(one_request_a, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request taken while one is in work")
  `CFTU_ASSERT_ALWAYS(div_norm_a, state_q == ST_DIV |-> div_q[WORD_W], "division started with an unnormalised divisor")
  `CFTU_ASSERT_ALWAYS(sqr_count_a, state_q == ST_SQR |-> cnt_q < CNT_W'(WORD_W), "square step count ran past the word width")

endmodule
